[sv/mrt_pkg.sv]
// shared types and constants for the markdown run tokenizer
// token kinds, result records, character codes and position width
// no dependencies
package mrt_pkg;

	localparam int POS_BITS   = 32;
	localparam int OUT_BITS   = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
	localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

	typedef logic [POS_BITS-1:0] pos_t;

	typedef enum logic [3:0] {
		KIND_HEADER = 4'd0,
		KIND_BREAK  = 4'd1,
		KIND_LIST   = 4'd2,
		KIND_SPACE  = 4'd3,
		KIND_EMPH   = 4'd4,
		KIND_POPEN  = 4'd5,
		KIND_PCLOSE = 4'd6,
		KIND_SOPEN  = 4'd7,
		KIND_SCLOSE = 4'd8,
		KIND_BANG   = 4'd9,
		KIND_BSLASH = 4'd10,
		KIND_NUM    = 4'd11,
		KIND_QUOTE  = 4'd12,
		KIND_TEXT   = 4'd13,
		KIND_NONE   = 4'd15
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [OUT_BITS-1:0] offset;
		logic [OUT_BITS-1:0] len;
		logic                last;
	} tok_t;

	// up to two tokens produced by one request
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       tok0;
		tok_t       tok1;
	} res_pair_t;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_UNDER = 8'h5F;

endpackage

[sv/mrt_ifs.sv]
// valid/ready channel interfaces for the markdown run tokenizer
// depends on mrt_pkg
interface mrt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] src_byte;
	logic       end_mark;

	modport source (output valid, output src_byte, output end_mark, input ready);
	modport sink (input valid, input src_byte, input end_mark, output ready);
endinterface

interface mrt_out_if;
	logic                         valid;
	logic                         ready;
	mrt_pkg::kind_t               tok_kind;
	logic [mrt_pkg::OUT_BITS-1:0] tok_offset;
	logic [mrt_pkg::OUT_BITS-1:0] tok_len;
	logic                         run_last;

	modport source (output valid, output tok_kind, output tok_offset, output tok_len,
		output run_last, input ready);
	modport sink (input valid, input tok_kind, input tok_offset, input tok_len,
		input run_last, output ready);
endinterface

[sv/mrt_core.sv]
// tokenizer state and per-byte classification
// holds the lookahead byte and the run/token state, produces up to two tokens per request
// depends on mrt_pkg
module mrt_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [7:0]         src_byte,
	input  logic               end_mark,
	output mrt_pkg::res_pair_t res
);
	import mrt_pkg::*;

	typedef struct packed {
		kind_t prior;
		kind_t tokk;
		kind_t scank;
		kind_t brk;
		logic  mid;
		logic  first;
		pos_t  tbeg;
		pos_t  cnt;
		pos_t  pos;
	} st_t;

	typedef struct packed {
		kind_t kind;
		kind_t brk;
	} cls_t;

	typedef struct packed {
		st_t  st;
		logic emit;
		tok_t tok;
	} cons_t;

	localparam st_t ST_RST = '{
		prior: KIND_NONE, tokk: KIND_NONE, scank: KIND_NONE, brk: KIND_NONE,
		mid: 1'b0, first: 1'b1, tbeg: '0, cnt: '0, pos: '0
	};

	function automatic cls_t classify(logic [7:0] b, logic sq, kind_t prior, kind_t brk,
		logic first);
		cls_t r;
		logic head;
		head = (prior == KIND_BREAK);
		r.kind = KIND_TEXT;
		r.brk = brk;
		case (b)
			CH_LF: r.kind = KIND_BREAK;
			CH_HASH: if (head || first) r.kind = KIND_HEADER;
			CH_GT: if (head || first) r.kind = KIND_QUOTE;
			CH_MINUS, CH_PLUS: if (head) r.kind = KIND_LIST;
			CH_STAR, CH_UNDER: r.kind = KIND_EMPH;
			CH_LBRK: r.kind = KIND_SOPEN;
			CH_RBRK: begin
				r.kind = KIND_SCLOSE;
				r.brk = KIND_SCLOSE;
			end
			CH_LPAR: begin
				if (prior == KIND_SCLOSE) begin
					r.kind = KIND_POPEN;
					r.brk = KIND_POPEN;
				end
			end
			CH_RPAR: if (brk == KIND_POPEN) r.kind = KIND_PCLOSE;
			CH_BANG: if (sq) r.kind = KIND_BANG;
			CH_SPACE: if (prior != KIND_TEXT) r.kind = KIND_SPACE;
			default: begin
				if ((b inside {[CH_ZERO:CH_NINE]} || b == CH_DOT) && head)
					r.kind = KIND_NUM;
			end
		endcase
		return r;
	endfunction

	function automatic cons_t consume(st_t s, logic [7:0] b, logic sq);
		cons_t r;
		cls_t  c1;
		cls_t  c2;
		kind_t p2;
		kind_t b2;
		logic  m2;
		kind_t tk;
		pos_t  bg;
		pos_t  cn;
		r.st = s;
		r.emit = 1'b0;
		r.tok = '{kind: s.tokk, offset: OUT_BITS'(s.tbeg), len: OUT_BITS'(s.cnt), last: 1'b1};
		c1 = classify(b, sq, s.prior, s.brk, s.first);
		p2 = s.prior;
		b2 = s.brk;
		m2 = s.mid;
		tk = s.tokk;
		bg = s.tbeg;
		cn = s.cnt;
		r.st.pos = s.pos + pos_t'(1);
		r.st.first = 1'b0;
		if (s.mid && s.scank != KIND_NONE && c1.kind == s.scank) begin
			// same kind extends the current run
			r.st.brk = c1.brk;
			r.st.cnt = s.cnt + pos_t'(1);
		end else begin
			if (s.mid && s.scank != KIND_NONE) begin
				// run ends: bracket state follows the finished run
				if (s.scank == KIND_POPEN || s.scank == KIND_SOPEN)
					b2 = s.scank;
				else if (s.scank == KIND_PCLOSE || s.scank == KIND_SCLOSE)
					b2 = KIND_NONE;
				else
					b2 = c1.brk;
				p2 = s.scank;
				m2 = 1'b0;
			end
			if (!m2 && b == CH_TAB) begin
				r.st.brk = b2;
				r.st.prior = p2;
				r.st.mid = 1'b1;
				r.st.scank = KIND_NONE;
			end else begin
				c2 = classify(b, sq, p2, b2, s.first);
				if (c2.kind != tk && tk != KIND_NONE) begin
					r.emit = 1'b1;
					p2 = tk;
					tk = KIND_NONE;
				end
				if (tk == KIND_NONE) begin
					tk = c2.kind;
					bg = s.pos;
					cn = '0;
				end
				r.st.brk = c2.brk;
				r.st.prior = p2;
				r.st.tokk = tk;
				r.st.tbeg = bg;
				r.st.cnt = cn + pos_t'(1);
				r.st.mid = 1'b1;
				r.st.scank = c2.kind;
			end
		end
		return r;
	endfunction

	st_t        st_q;
	st_t        st_n;
	st_t        st_mid;
	logic [7:0] held_q;
	logic       hv_q;
	cons_t      c_in;
	tok_t       fin_tok;
	logic       e0;
	logic       e1;

	always_comb begin
		c_in = consume(st_q, held_q, !end_mark && src_byte == CH_LBRK);
		st_mid = hv_q ? c_in.st : st_q;
		e0 = hv_q && c_in.emit;
		e1 = (st_mid.tokk != KIND_NONE);
		fin_tok = '{kind: st_mid.tokk, offset: OUT_BITS'(st_mid.tbeg),
			len: OUT_BITS'(st_mid.cnt), last: 1'b1};
		if (!end_mark) begin
			st_n = st_mid;
			res.cnt = {1'b0, e0};
			res.tok0 = c_in.tok;
			res.tok1 = c_in.tok;
		end else begin
			// end of source: flush and return to the reset state
			st_n = ST_RST;
			res.cnt = 2'(e0) + 2'(e1);
			res.tok0 = e0 ? c_in.tok : fin_tok;
			res.tok0.last = !(e0 && e1);
			res.tok1 = fin_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RST;
			held_q <= '0;
			hv_q <= 1'b0;
		end else if (fire) begin
			st_q <= st_n;
			held_q <= end_mark ? 8'h00 : src_byte;
			hv_q <= !end_mark;
		end
	end

endmodule

[sv/mrt_res_fifo.sv]
// small result queue taking up to two tokens per cycle, draining one per cycle while res_ch is ready
// depends on mrt_pkg and mrt_out_if
module mrt_res_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  mrt_pkg::res_pair_t push,
	output logic               room,
	mrt_out_if.source          res_ch
);
	import mrt_pkg::*;

	tok_t                mem [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wp_q;
	logic [PTR_BITS-1:0] rp_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                pop;

	assign room = (cnt_q <= CNT_BITS'(FIFO_DEPTH - 2));
	assign pop = res_ch.valid && res_ch.ready;

	assign res_ch.valid = (cnt_q != '0);
	assign res_ch.tok_kind = mem[rp_q].kind;
	assign res_ch.tok_offset = mem[rp_q].offset;
	assign res_ch.tok_len = mem[rp_q].len;
	assign res_ch.run_last = mem[rp_q].last;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem[wp_q] <= push.tok0;
		if (push.cnt == 2'd2)
			mem[wp_q + PTR_BITS'(1)] <= push.tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + PTR_BITS'(push.cnt);
			if (pop)
				rp_q <= rp_q + PTR_BITS'(1);
			cnt_q <= cnt_q + CNT_BITS'(push.cnt) - CNT_BITS'(pop);
		end
	end

endmodule

[sv/markdown_run_tokenizer.sv]
// markdown run tokenizer top level: input stage, tokenizer core, result queue
// depends on mrt_pkg, mrt_ifs, mrt_core, mrt_res_fifo
//
// channel   dir  payload                                   request taken when
// src_ch    in   src_byte[8], end_mark[1]                  valid && ready
// res_ch    out  tok_kind[4], tok_offset[32], tok_len[32], valid && ready
//                run_last[1]
//
// a request is registered; when it fires, the held byte is classified with the new byte
// as lookahead, merged into the token state, and its tokens go to the result queue. one
// request per cycle is taken while the queue has room and each yields at most one token;
// an end request yielding two tokens drains them one at a time through the single read
// port of the four-entry result queue. reset clears control and token state at once, no
// clearing pass. a stalled res_ch backs up into the queue and then drops src_ch.ready.
module markdown_run_tokenizer (
	input logic clk,
	input logic arst_n,
	mrt_in_if.sink    src_ch,
	mrt_out_if.source res_ch
);
	import mrt_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       room;
	logic       fire;
	res_pair_t  pair;
	res_pair_t  push;

	assign fire = vld_s1 && room;
	assign src_ch.ready = !vld_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (src_ch.valid && src_ch.ready) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ch.valid && src_ch.ready) begin
			byte_s1 <= src_ch.src_byte;
			end_s1 <= src_ch.end_mark;
		end
	end

	mrt_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.src_byte (byte_s1),
		.end_mark (end_s1),
		.res      (pair)
	);

	always_comb begin
		push = pair;
		if (!fire)
			push.cnt = 2'd0;
	end

	mrt_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.res_ch (res_ch)
	);

endmodule

[tb/tb_markdown_run_tokenizer.sv]
`timescale 1ns / 1ps
// self-checking testbench for markdown_run_tokenizer: byte streams in, tokens checked in order
// depends on mrt_pkg, mrt_ifs and the markdown_run_tokenizer rtl
module tb_markdown_run_tokenizer;
	import mrt_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int TARGET_REQS  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int NFRAG        = 12;

	// token predictor with its own copy of the lexer state and the expected token queue
	class token_board;
		kind_t      last_kind, cur_kind, run_kind, brk_kind;
		logic [7:0] held_byte;
		bit         held_ok, in_run, first_byte;
		pos_t       tok_start, tok_count, pos;
		tok_t       want_toks[$];
		int         errors, matched;
		bit [15:0]  kinds_seen;

		function new();
			errors = 0;
			matched = 0;
			kinds_seen = '0;
			want_toks.delete();
			clear();
		endfunction

		function void clear();
			held_byte = 8'h00;
			held_ok = 1'b0;
			last_kind = KIND_NONE;
			cur_kind = KIND_NONE;
			run_kind = KIND_NONE;
			in_run = 1'b0;
			brk_kind = KIND_NONE;
			first_byte = 1'b1;
			tok_start = '0;
			tok_count = '0;
			pos = '0;
		endfunction

		// context classification; ']' and a link '(' also move the bracket state
		function kind_t kind_of(logic [7:0] b, bit next_lbrk);
			bit line_head;
			line_head = (last_kind == KIND_BREAK);
			case (b)
				CH_LF: return KIND_BREAK;
				CH_HASH: return (line_head || first_byte) ? KIND_HEADER : KIND_TEXT;
				CH_GT: return (line_head || first_byte) ? KIND_QUOTE : KIND_TEXT;
				CH_MINUS, CH_PLUS: return line_head ? KIND_LIST : KIND_TEXT;
				CH_STAR, CH_UNDER: return KIND_EMPH;
				CH_LBRK: return KIND_SOPEN;
				CH_RBRK: begin
					brk_kind = KIND_SCLOSE;
					return KIND_SCLOSE;
				end
				CH_LPAR: begin
					if (last_kind == KIND_SCLOSE) begin
						brk_kind = KIND_POPEN;
						return KIND_POPEN;
					end
					return KIND_TEXT;
				end
				CH_RPAR: return (brk_kind == KIND_POPEN) ? KIND_PCLOSE : KIND_TEXT;
				CH_BANG: return next_lbrk ? KIND_BANG : KIND_TEXT;
				CH_SPACE: return (last_kind != KIND_TEXT) ? KIND_SPACE : KIND_TEXT;
				default: begin
					if (((b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT) && line_head)
						return KIND_NUM;
					return KIND_TEXT;
				end
			endcase
		endfunction

		function void step_pos();
			pos = pos + 1'b1;
			first_byte = 1'b0;
		endfunction

		function void close_run();
			if (run_kind == KIND_POPEN || run_kind == KIND_SOPEN)
				brk_kind = run_kind;
			else if (run_kind == KIND_PCLOSE || run_kind == KIND_SCLOSE)
				brk_kind = KIND_NONE;
			last_kind = run_kind;
			in_run = 1'b0;
			run_kind = KIND_NONE;
		endfunction

		function void push_token();
			tok_t t;
			t.kind = cur_kind;
			t.offset = tok_start;
			t.len = tok_count;
			t.last = 1'b0;
			want_toks.push_back(t);
			last_kind = cur_kind;
			cur_kind = KIND_NONE;
			tok_count = '0;
		endfunction

		function void lex_byte(logic [7:0] b, bit next_lbrk);
			kind_t k;
			if (in_run && run_kind != KIND_NONE) begin
				k = kind_of(b, next_lbrk);
				if (k == run_kind) begin
					tok_count = tok_count + 1'b1;
					step_pos();
					return;
				end
				close_run();
			end
			// one tab in front of a run is skipped
			if (!in_run && b == CH_TAB) begin
				step_pos();
				in_run = 1'b1;
				run_kind = KIND_NONE;
				return;
			end
			k = kind_of(b, next_lbrk);
			if (k != cur_kind && cur_kind != KIND_NONE)
				push_token();
			if (cur_kind == KIND_NONE) begin
				cur_kind = k;
				tok_start = pos;
				tok_count = '0;
			end
			tok_count = tok_count + 1'b1;
			step_pos();
			in_run = 1'b1;
			run_kind = k;
		endfunction

		// accepted request: the held byte is lexed once its lookahead is known
		function void note_request(logic [7:0] b, logic e);
			int n_prev;
			n_prev = want_toks.size();
			if (!e) begin
				if (held_ok)
					lex_byte(held_byte, b == CH_LBRK);
				held_byte = b;
				held_ok = 1'b1;
			end else begin
				if (held_ok)
					lex_byte(held_byte, 1'b0);
				if (cur_kind != KIND_NONE)
					push_token();
				clear();
			end
			if (want_toks.size() > n_prev)
				want_toks[want_toks.size() - 1].last = 1'b1;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_token(kind_t k, logic [31:0] off, logic [31:0] len, logic last);
			tok_t w;
			if (want_toks.size() == 0) begin
				report($sformatf("unexpected token kind %0d offset %0d len %0d", k, off, len));
				return;
			end
			w = want_toks.pop_front();
			if (k !== w.kind)
				report($sformatf("tok_kind got %0d want %0d", k, w.kind));
			if (off !== w.offset)
				report($sformatf("tok_offset got %0d want %0d", off, w.offset));
			if (len !== w.len)
				report($sformatf("tok_len got %0d want %0d", len, w.len));
			if (last !== w.last)
				report($sformatf("run_last got %0b want %0b", last, w.last));
			kinds_seen[w.kind] = 1'b1;
			matched++;
		endtask

		function int pending();
			return want_toks.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mrt_in_if  src_ch();
	mrt_out_if res_ch();

	markdown_run_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_ch(src_ch),
		.res_ch(res_ch)
	);

	token_board board;
	int  cycles;
	int  n_reqs;
	int  n_sources;
	int  n_tokens;
	bit  fast_src;
	bit  rx_hold;

	string alpha = "\n#>-+*_[]()! \t.09a";
	string frags[NFRAG] = '{"![x]", "[a](b)", "\n- ", "\n+ ", "\n12.", "\n# ",
		"\n> ", "**", "  ", "\t", "\t\t", "](c)"};

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d tokens outstanding", cycles, board.pending());
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			board.check_token(res_ch.tok_kind, res_ch.tok_offset, res_ch.tok_len,
				res_ch.run_last);
			n_tokens++;
		end
	end

	// token receiver with random stalls and one long hold-off
	initial begin
		int  w;
		bit  held;
		bit  rx_fast;
		held = 1'b0;
		rx_fast = 1'b0;
		rx_hold = 1'b0;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held && n_tokens >= 150) begin
				held = 1'b1;
				rx_hold = 1'b1;
				res_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold = 1'b0;
			end
			if (n_tokens % 32 == 0)
				rx_fast = ($urandom_range(0, 2) == 0);
			w = rx_fast ? 0 : $urandom_range(0, 9);
			if (w > 0) begin
				res_ch.ready = 1'b0;
				repeat (w) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// entered and left at a falling edge
	task automatic send_req(input logic [7:0] b, input logic e);
		int gap;
		gap = (fast_src || rx_hold) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			src_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_ch.valid = 1'b1;
		src_ch.src_byte = b;
		src_ch.end_mark = e;
		do @(posedge clk); while (!src_ch.ready);
		board.note_request(b, e);
		n_reqs++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_req(s[i], 1'b0);
	endtask

	task automatic send_end();
		send_req(8'($urandom_range(0, 255)), 1'b1);
		n_sources++;
	endtask

	task automatic drain();
		src_ch.valid = 1'b0;
		while (board.pending() != 0) @(negedge clk);
	endtask

	initial begin
		int    len;
		int    cnt;
		int    mode;
		bit    paused;
		string f;
		board = new();
		cycles = 0;
		n_reqs = 0;
		n_sources = 0;
		n_tokens = 0;
		fast_src = 1'b0;
		paused = 1'b0;
		arst_n = 1'b0;
		src_ch.valid = 1'b0;
		src_ch.src_byte = 8'h00;
		src_ch.end_mark = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// end with nothing pending, quote at the start, tab right before the end
		send_end();
		send_text(">\t");
		send_end();
		// each kind but number, quote and backslash, zero and all-ones bytes, bang with no byte after it
		send_text("#\n-1![a](b)*_ ");
		send_req(8'h00, 1'b0);
		send_req(8'hFF, 1'b0);
		send_req(CH_BANG, 1'b0);
		send_end();
		drain();

		while (n_reqs < TARGET_REQS) begin
			fast_src = ($urandom_range(0, 3) == 0);
			if (!paused && n_reqs >= TARGET_REQS / 2) begin
				drain();
				paused = 1'b1;
			end
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				// raw noise, possibly empty
				len = $urandom_range(0, 20);
				repeat (len) send_req(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 150)
					: $urandom_range(1, 30);
				cnt = 0;
				while (cnt < len) begin
					if ($urandom_range(0, 2) == 0) begin
						f = frags[$urandom_range(0, NFRAG - 1)];
						send_text(f);
						cnt += f.len();
					end else begin
						if ($urandom_range(0, 9) == 0)
							send_req(8'($urandom_range(0, 255)), 1'b0);
						else
							send_req(alpha[$urandom_range(0, alpha.len() - 1)], 1'b0);
						cnt++;
					end
				end
			end
			send_end();
		end
		fast_src = 1'b0;
		drain();
		repeat (20) @(posedge clk);

		$display("sent %0d requests in %0d sources, checked %0d tokens in %0d cycles",
			n_reqs, n_sources, board.matched, cycles);
		$display("token kinds seen (bit per kind): %b", board.kinds_seen);
		if (board.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", board.errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
